>>> rtl/core/rrts_pkg.sv
package rrts_pkg;

    // Table size and time base
    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int TIME_W      = 16;
    localparam int QUANT_W     = 8;
    localparam int COUNT_W     = 5;
    localparam int CFG_DATA_W  = 8;
    localparam int CFG_IDX_W   = 1;
    localparam int ENTRY_W     = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_QUANTUM = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT   = 1'b1;

    // Item modes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;     // write one table entry
        logic capture;  // latch the ready vector for a tick
        logic commit;   // grant, update the table and issue the result
    } rrts_cmd_t;

endpackage

>>> rtl/core/rrts_ctrl.sv
module rrts_ctrl
    import rrts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      mode,
    output logic      busy,
    output rrts_cmd_t cmd
);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_SEARCH = 1'b1;

    logic state_reg;
    logic state_next;
    logic accept;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cmd.load    = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (mode == MODE_TICK)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = ST_SEARCH;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_SEARCH:
            begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/core/rrts_dp.sv
module rrts_dp
    import rrts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  rrts_cmd_t             cmd,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [ENTRY_W-1:0]    entry_index,
    input  logic [TIME_W-1:0]     arrival_time,
    input  logic [TIME_W-1:0]     burst_length,
    output logic                  result_strobe,
    output logic [TIME_W-1:0]     tick_time,
    output logic [ENTRY_W-1:0]    running_entry,
    output logic                  idle,
    output logic                  finished,
    output logic [TIME_W-1:0]     finished_wait
);

    // Configuration
    logic [QUANT_W-1:0] quantum_reg;
    logic [COUNT_W-1:0] count_reg;

    // Entry table and scheduler state
    logic [TIME_W-1:0]      arrival_reg   [MAX_ENTRIES];
    logic [TIME_W-1:0]      remaining_reg [MAX_ENTRIES];
    logic [TIME_W-1:0]      wait_reg      [MAX_ENTRIES];
    logic [TIME_W-1:0]      now_reg;
    logic [IDX_W-1:0]       cur_reg;
    logic [QUANT_W-1:0]     slice_reg;
    logic [MAX_ENTRIES-1:0] rdy_reg;

    // Result registers
    logic                   strobe_reg;
    logic [TIME_W-1:0]      tick_time_reg;
    logic [ENTRY_W-1:0]     running_reg;
    logic                   idle_reg;
    logic                   finished_reg;
    logic [TIME_W-1:0]      fwait_reg;

    logic [CNT_W-1:0]         used_n;
    logic [MAX_ENTRIES-1:0]   rdy_now;
    logic [CNT_W-1:0]         nxt;
    logic [IDX_W-1:0]         start_idx;
    logic [2*MAX_ENTRIES-1:0] dbl;
    logic [MAX_ENTRIES-1:0]   rot;
    logic [IDX_W-1:0]         offset;
    logic [IDX_W:0]           sum;
    logic [IDX_W-1:0]         chosen;
    logic                     keep;
    logic                     found;
    logic [IDX_W-1:0]         grant;
    logic                     load_ok;

    // Clamp the entry count to the table size
    always_comb
    begin
        if (int'(count_reg) > MAX_ENTRIES)
        begin
            used_n = CNT_W'(MAX_ENTRIES);
        end
        else
        begin
            used_n = CNT_W'(count_reg);
        end
    end

    // Ready: in use, arrived and with work left
    always_comb
    begin
        for (int k = 0; k < MAX_ENTRIES; k++)
        begin
            rdy_now[k] = (CNT_W'(k) < used_n) && (arrival_reg[k] <= now_reg)
                         && (remaining_reg[k] != '0);
        end
    end

    // Keep the current entry or search circularly after it
    always_comb
    begin
        nxt = CNT_W'(cur_reg) + CNT_W'(1);
        if (nxt >= used_n)
        begin
            start_idx = '0;
        end
        else
        begin
            start_idx = nxt[IDX_W-1:0];
        end
        dbl    = {rdy_reg, rdy_reg};
        rot    = MAX_ENTRIES'(dbl >> start_idx);
        offset = '0;
        for (int j = MAX_ENTRIES - 1; j >= 0; j--)
        begin
            if (rot[j])
            begin
                offset = IDX_W'(j);
            end
        end
        sum = {1'b0, start_idx} + {1'b0, offset};
        if (int'(sum) >= MAX_ENTRIES)
        begin
            sum = sum - (IDX_W + 1)'(MAX_ENTRIES);
        end
        chosen = sum[IDX_W-1:0];
        keep   = rdy_reg[cur_reg] && (slice_reg < quantum_reg);
        found  = keep || (|rdy_reg);
        grant  = keep ? cur_reg : chosen;
    end

    assign load_ok = (int'(entry_index) < MAX_ENTRIES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg <= QUANT_W'(1);
            count_reg   <= COUNT_W'(MAX_ENTRIES);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_QUANTUM: quantum_reg <= cfg_data[QUANT_W-1:0];
                REG_COUNT:   count_reg   <= cfg_data[COUNT_W-1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_ENTRIES; k++)
            begin
                arrival_reg[k]   <= '0;
                remaining_reg[k] <= '0;
                wait_reg[k]      <= '0;
            end
            now_reg    <= '0;
            cur_reg    <= '0;
            slice_reg  <= '0;
            rdy_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.commit;
            if (cmd.load && load_ok)
            begin
                arrival_reg[IDX_W'(entry_index)]   <= arrival_time;
                remaining_reg[IDX_W'(entry_index)] <= burst_length;
                wait_reg[IDX_W'(entry_index)]      <= '0;
            end
            if (cmd.capture)
            begin
                rdy_reg <= rdy_now;
            end
            if (cmd.commit)
            begin
                now_reg <= now_reg + TIME_W'(1);
                if (found)
                begin
                    for (int k = 0; k < MAX_ENTRIES; k++)
                    begin
                        if ((IDX_W'(k) != grant) && rdy_reg[k] && (wait_reg[k] != '1))
                        begin
                            wait_reg[k] <= wait_reg[k] + TIME_W'(1);
                        end
                    end
                    remaining_reg[grant] <= remaining_reg[grant] - TIME_W'(1);
                    cur_reg              <= grant;
                    slice_reg            <= keep ? slice_reg + QUANT_W'(1) : QUANT_W'(1);
                end
                else
                begin
                    slice_reg <= '0;
                end
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            tick_time_reg <= now_reg;
            idle_reg      <= !found;
            running_reg   <= found ? ENTRY_W'(grant) : '0;
            finished_reg  <= found && (remaining_reg[grant] == TIME_W'(1));
            fwait_reg     <= (found && (remaining_reg[grant] == TIME_W'(1)))
                             ? wait_reg[grant] : '0;
        end
    end

    assign result_strobe = strobe_reg;
    assign tick_time     = tick_time_reg;
    assign running_entry = running_reg;
    assign idle          = idle_reg;
    assign finished      = finished_reg;
    assign finished_wait = fwait_reg;

endmodule

>>> rtl/core/round_robin_time_slice_scheduler.sv
// Round-robin time-slice scheduler over a sixteen-entry table.
// Input: raise start with mode, entry_index, arrival_time and burst_length;
// the item transfers at a rising edge where start is high and busy is low.
// A load (mode 0) writes one entry at the accepting edge; busy stays low.
// A tick (mode 1) latches the ready vector of every entry at the accepting
// edge; the search state that follows runs the rotating priority search,
// updates the table and registers the result. The result then appears on
// tick_time, running_entry, idle, finished and finished_wait as
// result_strobe goes high for exactly one cycle; busy is already low in
// that cycle, so the next tick can be accepted in the strobe cycle.
// Configuration: cfg_write, cfg_index and cfg_data write time_quantum
// (index 0) or entry_count (index 1) at any edge where cfg_write is high;
// write only while no tick is in progress.
// Reset (rst_n low, asynchronous) empties the table, clears time and the
// slice count and restores quantum 1 and entry count 16.
// The receiver cannot stall: every result transfers in its strobe cycle.
module round_robin_time_slice_scheduler
    import rrts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  mode,
    input  logic [ENTRY_W-1:0]    entry_index,
    input  logic [TIME_W-1:0]     arrival_time,
    input  logic [TIME_W-1:0]     burst_length,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  result_strobe,
    output logic [TIME_W-1:0]     tick_time,
    output logic [ENTRY_W-1:0]    running_entry,
    output logic                  idle,
    output logic                  finished,
    output logic [TIME_W-1:0]     finished_wait
);

    // Command bundle from the sequencer to the table
    rrts_cmd_t cmd;

    rrts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .busy  (busy),
        .cmd   (cmd)
    );

    rrts_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .entry_index   (entry_index),
        .arrival_time  (arrival_time),
        .burst_length  (burst_length),
        .result_strobe (result_strobe),
        .tick_time     (tick_time),
        .running_entry (running_entry),
        .idle          (idle),
        .finished      (finished),
        .finished_wait (finished_wait)
    );

endmodule
